// ----- hw/rtl/msp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the motor speed PI duty block: field widths, register indexes,
// mode codes, reset values and the structs shared by the modules. No dependencies.
package msp_pkg;

	localparam int COUNT_W  = 11;
	localparam int MODE_W   = 2;
	localparam int TARGET_W = 19;
	localparam int GAIN_W   = 16;
	localparam int BASE_W   = 18;
	localparam int ERR_W    = 21;
	localparam int DIFF_W   = ERR_W + 1;
	localparam int PPROP_W  = GAIN_W + 1 + DIFF_W;
	localparam int PINT_W   = GAIN_W + 1 + ERR_W;
	localparam int ACC_W    = 41;
	localparam int FRAC_W   = 20;
	localparam int IDX_W    = 8;
	localparam int DATA_W   = 19;

	localparam logic [IDX_W-1:0] REG_TARGET = 8'd0;
	localparam logic [IDX_W-1:0] REG_PROP   = 8'd1;
	localparam logic [IDX_W-1:0] REG_INTEG  = 8'd2;
	localparam logic [IDX_W-1:0] REG_BASE   = 8'd3;

	localparam logic [MODE_W-1:0] MODE_STOP     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FORWARD  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BACKWARD = 2'd2;

	localparam logic [TARGET_W-1:0] TARGET_RST = 19'd13345;
	localparam logic [GAIN_W-1:0]   PROP_RST   = 16'd8192;
	localparam logic [GAIN_W-1:0]   INTEG_RST  = 16'd82;
	localparam logic [BASE_W-1:0]   BASE_RST   = 18'd161498;

	typedef struct packed {
		logic [TARGET_W-1:0] target_pulses;
		logic [GAIN_W-1:0]   prop_gain;
		logic [GAIN_W-1:0]   integ_gain;
		logic [BASE_W-1:0]   base_duty;
	} cfg_regs_t;

	typedef struct packed {
		logic                     stop;
		logic signed [ERR_W-1:0]  error;
		logic signed [DIFF_W-1:0] diff;
	} err_item_t;

endpackage

// ----- hw/rtl/msp_sample_if.sv -----
`timescale 1ns / 1ps
// Input channel of the motor speed PI duty block: one item per control tick.
// Depends on msp_pkg for the field widths.
interface msp_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [msp_pkg::COUNT_W-1:0]   enc_count;
	logic        [msp_pkg::MODE_W-1:0]    motor_mode;

	modport source (output valid, output enc_count, output motor_mode, input ready);
	modport sink (input valid, input enc_count, input motor_mode, output ready);
endinterface

// ----- hw/rtl/msp_result_if.sv -----
`timescale 1ns / 1ps
// Output channel of the motor speed PI duty block: one duty item per tick.
// The duty width follows the DUTY_BITS parameter.
interface msp_result_if #(
	parameter int DUTY_BITS = 10
);
	logic                 valid;
	logic                 ready;
	logic [DUTY_BITS-1:0] duty;

	modport source (output valid, output duty, input ready);
	modport sink (input valid, input duty, output ready);
endinterface

// ----- hw/rtl/msp_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel of the motor speed PI duty block.
// Depends on msp_pkg for the index and data widths.
interface msp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [msp_pkg::IDX_W-1:0]     reg_index;
	logic [msp_pkg::DATA_W-1:0]    wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- hw/rtl/msp_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration registers of the motor speed PI duty block.
// Depends on msp_pkg and msp_cfg_if.
module msp_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	msp_cfg_if.sink            cfg,
	output msp_pkg::cfg_regs_t regs
);

	msp_pkg::cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.target_pulses <= msp_pkg::TARGET_RST;
			regs_q.prop_gain     <= msp_pkg::PROP_RST;
			regs_q.integ_gain    <= msp_pkg::INTEG_RST;
			regs_q.base_duty     <= msp_pkg::BASE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				msp_pkg::REG_TARGET: regs_q.target_pulses <= cfg.wdata[msp_pkg::TARGET_W-1:0];
				msp_pkg::REG_PROP:   regs_q.prop_gain <= cfg.wdata[msp_pkg::GAIN_W-1:0];
				msp_pkg::REG_INTEG:  regs_q.integ_gain <= cfg.wdata[msp_pkg::GAIN_W-1:0];
				msp_pkg::REG_BASE:   regs_q.base_duty <= cfg.wdata[msp_pkg::BASE_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- hw/rtl/msp_err_stage.sv -----
`timescale 1ns / 1ps
// Input register and error stage: speed error, error change and the kept error.
// Depends on msp_pkg and msp_sample_if.
module msp_err_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	msp_sample_if.sink            sample,
	input  msp_pkg::cfg_regs_t    regs,
	output logic                  item_valid,
	output msp_pkg::err_item_t    item,
	input  logic                  item_ready
);

	logic                                valid_s1;
	logic signed [msp_pkg::COUNT_W-1:0]  count_s1;
	logic        [msp_pkg::MODE_W-1:0]   mode_s1;
	logic                                valid_s2;
	msp_pkg::err_item_t                  item_s2;
	logic signed [msp_pkg::ERR_W-1:0]    prev_err_q;

	logic                                ready_s1;
	logic                                ready_s2;
	logic                                run;
	logic        [msp_pkg::COUNT_W-1:0]  mag;
	logic signed [msp_pkg::ERR_W-1:0]    error;
	logic signed [msp_pkg::DIFF_W-1:0]   diff;

	assign ready_s2 = !valid_s2 || item_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign sample.ready = ready_s1;
	assign item_valid = valid_s2;
	assign item = item_s2;

	assign run = (mode_s1 == msp_pkg::MODE_FORWARD) || (mode_s1 == msp_pkg::MODE_BACKWARD);
	assign mag = count_s1[msp_pkg::COUNT_W-1] ? ((~count_s1) + 11'd1) : count_s1;
	assign error = $signed({2'b00, regs.target_pulses}) - $signed({2'b00, mag, 8'd0});
	assign diff = $signed({error[msp_pkg::ERR_W-1], error})
		- $signed({prev_err_q[msp_pkg::ERR_W-1], prev_err_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && sample.valid) begin
			count_s1 <= sample.enc_count;
			mode_s1 <= sample.motor_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			prev_err_q <= '0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s2 && valid_s1) begin
				prev_err_q <= run ? error : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			item_s2.stop <= !run;
			item_s2.error <= error;
			item_s2.diff <= diff;
		end
	end

endmodule

// ----- hw/rtl/msp_mac.sv -----
`timescale 1ns / 1ps
// Gain products, feedforward sum and duty saturation with the result register.
// Depends on msp_pkg and msp_result_if.
module msp_mac #(
	parameter int DUTY_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  msp_pkg::cfg_regs_t regs,
	input  logic               item_valid,
	input  msp_pkg::err_item_t item,
	output logic               item_ready,
	msp_result_if.source       result
);

	localparam int HI_W = msp_pkg::ACC_W - 1 - msp_pkg::FRAC_W;
	localparam logic [HI_W-1:0] DUTY_MAX = HI_W'((64'd1 << DUTY_BITS) - 64'd1);

	logic                                valid_s3;
	logic                                stop_s3;
	logic signed [msp_pkg::PPROP_W-1:0]  pprop_s3;
	logic signed [msp_pkg::PINT_W-1:0]   pint_s3;
	logic                                valid_s4;
	logic        [DUTY_BITS-1:0]         duty_s4;

	logic                                ready_s3;
	logic                                ready_s4;
	logic signed [msp_pkg::ACC_W-1:0]    acc;
	logic        [HI_W-1:0]              acc_hi;
	logic        [DUTY_BITS-1:0]         duty;

	assign ready_s4 = !valid_s4 || result.ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign item_ready = ready_s3;
	assign result.valid = valid_s4;
	assign result.duty = duty_s4;

	assign acc = msp_pkg::ACC_W'(pprop_s3) + msp_pkg::ACC_W'(pint_s3)
		+ $signed({{(msp_pkg::ACC_W - msp_pkg::BASE_W - 12){1'b0}}, regs.base_duty, 12'd0});
	assign acc_hi = acc[msp_pkg::ACC_W-2:msp_pkg::FRAC_W];

	always_comb begin
		priority if (stop_s3 || acc[msp_pkg::ACC_W-1]) begin
			duty = '0;
		end else if (acc_hi > DUTY_MAX) begin
			duty = DUTY_MAX[DUTY_BITS-1:0];
		end else begin
			duty = acc_hi[DUTY_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s3) begin
				valid_s3 <= item_valid;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && item_valid) begin
			stop_s3 <= item.stop;
			pprop_s3 <= $signed({1'b0, regs.prop_gain}) * item.diff;
			pint_s3 <= $signed({1'b0, regs.integ_gain}) * item.error;
		end
		if (ready_s4 && valid_s3) begin
			duty_s4 <= duty;
		end
	end

endmodule

// ----- hw/rtl/motor_speed_pi_duty.sv -----
`timescale 1ns / 1ps
// Motor speed PI controller with feedforward duty, top level.
// Depends on msp_pkg, the three channel interfaces, msp_cfg_regs, msp_err_stage, msp_mac.
//
// Each item on the sample channel is one control tick: the signed encoder pulse
// count of the tick and the motor mode. For each item one duty item leaves on
// the result channel, in order. Stop mode (or the unused mode code) gives duty 0
// and clears the kept error.
// The cfg channel writes target, proportional gain, integral gain and base duty
// by index; it is always ready and should only be written while no item is in
// flight. Writes to other indexes are dropped.
// The block is a four-register pipeline: input register, error stage, gain
// multipliers, sum and saturation into the result register. An accepted sample
// item passes through these registers in order before result.valid rises, and
// one item can be accepted every cycle while the pipeline does not stall. Each
// stage holds its item while the next is full, so a stalled receiver fills the
// pipeline before sample.ready drops; idle stages keep accepting meanwhile.
// Reset clears the pipeline and the kept error and loads the register defaults.
module motor_speed_pi_duty #(
	parameter int DUTY_BITS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	msp_cfg_if.sink       cfg,
	msp_sample_if.sink    sample,
	msp_result_if.source  result
);

	msp_pkg::cfg_regs_t  regs;
	logic                item_valid;
	logic                item_ready;
	msp_pkg::err_item_t  item;

	msp_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	msp_err_stage u_err_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.regs       (regs),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready)
	);

	msp_mac #(
		.DUTY_BITS (DUTY_BITS)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.regs       (regs),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready),
		.result     (result)
	);

endmodule
